// ----- hdl/cts_pkg.sv -----
// Shared types and constants for the crop trapezoid suitability core.
package cts_pkg;

  // Field widths of the pixel and result items
  localparam int TEMP_W     = 16;
  localparam int PREC_W     = 20;
  localparam int OUT_W      = 17;

  // Common signed width that holds both a temperature and a precipitation value
  localparam int VAL_W      = 21;
  // Width of a positive ramp span (largest is the precipitation span)
  localparam int SPAN_W     = 20;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_ABS_MIN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_OPT_LOW  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_OPT_HIGH = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_ABS_MAX  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREC_ABS_MIN  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PREC_OPT_LOW  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PREC_OPT_HIGH = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PREC_ABS_MAX  = 4'd7;

  // One pixel
  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic        [PREC_W-1:0] precipitation;
    logic                     temp_missing;
    logic                     prec_missing;
  } in_data_t;

  // One result
  typedef struct packed {
    logic [OUT_W-1:0] suitability;
    logic             no_data;
  } out_data_t;

  // Four trapezoid thresholds, already extended to the common signed width
  typedef struct packed {
    logic signed [VAL_W-1:0] lo_abs;
    logic signed [VAL_W-1:0] lo_opt;
    logic signed [VAL_W-1:0] hi_opt;
    logic signed [VAL_W-1:0] hi_abs;
  } thr_t;

endpackage

// ----- hdl/cts_trap_lane.sv -----
// One trapezoid membership lane: classify, form ramp span, then a one-bit-per-stage divider.
module cts_trap_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic signed [cts_pkg::VAL_W-1:0] in_val,
  input  cts_pkg::thr_t                    thr,
  output logic                             out_vld,
  output logic [FRAC_BITS:0]               out_mem
);

  localparam int VW = cts_pkg::VAL_W;
  localparam int SW = cts_pkg::SPAN_W;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Stage 1: compare against the four thresholds
  logic zero1, one1, below1;

  logic                 s1_vld_r;
  logic                 s1_zero_r, s1_one_r, s1_below_r;
  logic signed [VW-1:0] s1_val_r;
  cts_pkg::thr_t        s1_thr_r;

  assign zero1  = (in_val <= thr.lo_abs) || (in_val >= thr.hi_abs);
  assign one1   = (in_val >= thr.lo_opt) && (in_val <= thr.hi_opt);
  assign below1 = in_val < thr.lo_opt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_zero_r  <= zero1;
    s1_one_r   <= one1;
    s1_below_r <= below1;
    s1_val_r   <= in_val;
    s1_thr_r   <= thr;
  end

  // Stage 2: ramp span and numerator, zero-width ramps fold into zero
  logic signed [VW:0] span2, num2;
  logic               zero2, one2;

  always_comb begin
    if (s1_below_r) begin
      span2 = $signed({s1_thr_r.lo_opt[VW-1], s1_thr_r.lo_opt})
            - $signed({s1_thr_r.lo_abs[VW-1], s1_thr_r.lo_abs});
      num2  = $signed({s1_val_r[VW-1], s1_val_r})
            - $signed({s1_thr_r.lo_abs[VW-1], s1_thr_r.lo_abs});
    end else begin
      span2 = $signed({s1_thr_r.hi_abs[VW-1], s1_thr_r.hi_abs})
            - $signed({s1_thr_r.hi_opt[VW-1], s1_thr_r.hi_opt});
      num2  = $signed({s1_thr_r.hi_abs[VW-1], s1_thr_r.hi_abs})
            - $signed({s1_val_r[VW-1], s1_val_r});
    end
    zero2 = s1_zero_r ||
            (!s1_one_r && (span2[VW] || (span2 == '0) || num2[VW] || (num2 == '0)));
    one2  = s1_one_r && !s1_zero_r;
  end

  // Divider stages: index 0 is the stage-2 register, one quotient bit per stage
  logic                 dv_vld_r  [0:FRAC_BITS];
  logic                 dv_zero_r [0:FRAC_BITS];
  logic                 dv_one_r  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] dv_q_r    [0:FRAC_BITS];
  logic [SW-1:0]        dv_span_r [0:FRAC_BITS-1];
  logic [SW-1:0]        dv_rem_r  [0:FRAC_BITS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_zero_r[0] <= zero2;
    dv_one_r[0]  <= one2;
    dv_q_r[0]    <= '0;
    dv_span_r[0] <= span2[SW-1:0];
    dv_rem_r[0]  <= num2[SW-1:0];
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [SW:0]   rem2;
    logic [SW:0]   dif;
    logic          ge;

    // Restoring step; on a ramp sample the remainder always stays below the span
    assign rem2    = {dv_rem_r[k], 1'b0};
    assign dif     = rem2 - {1'b0, dv_span_r[k]};
    assign ge      = rem2 >= {1'b0, dv_span_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_zero_r[k+1] <= dv_zero_r[k];
      dv_one_r[k+1]  <= dv_one_r[k];
      dv_q_r[k+1]    <= {dv_q_r[k][FRAC_BITS-2:0], ge};
    end

    // Last stage only yields its quotient bit
    if (k < FRAC_BITS - 1) begin : g_fwd
      logic [SW-1:0] rem_nxt;

      assign rem_nxt = ge ? dif[SW-1:0] : rem2[SW-1:0];

      always_ff @(posedge clk) begin
        dv_span_r[k+1] <= dv_span_r[k];
        dv_rem_r[k+1]  <= rem_nxt;
      end
    end
  end

  // Membership select
  assign out_vld = dv_vld_r[FRAC_BITS];
  always_comb begin
    if (dv_zero_r[FRAC_BITS]) begin
      out_mem = '0;
    end else if (dv_one_r[FRAC_BITS]) begin
      out_mem = ONE;
    end else begin
      out_mem = {1'b0, dv_q_r[FRAC_BITS]};
    end
  end

endmodule

// ----- hdl/crop_trapezoid_suitability_core.sv -----
// Top level of the crop trapezoid suitability core: registers, two lanes, minimum, result.
//
//  channel  ports                                     direction  transfer when
//  pixel    in_start, in_data, busy                   in         in_start & !busy
//  result   out_valid, out_data                       out        out_valid (one cycle)
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid & cfg_ready
//
// One pixel per cycle, every cycle; busy is always low and cfg_ready always high.
// Each lane runs classify, span and the one-bit-per-stage restoring divider,
// followed by the result stage common to both lanes.
// Synchronous active-low reset clears valid bits and all eight threshold registers.
// The receiver cannot stall; results leave in order, one strobe each.
module crop_trapezoid_suitability_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_start,
  input  cts_pkg::in_data_t                  in_data,
  output logic                               busy,
  output logic                               out_valid,
  output cts_pkg::out_data_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int VW       = cts_pkg::VAL_W;
  localparam int TW       = cts_pkg::TEMP_W;
  localparam int PW       = cts_pkg::PREC_W;
  localparam int LANE_LAT = FRAC_BITS + 2;
  localparam int PIPE_LAT = FRAC_BITS + 3;

  // Handshake
  logic in_acc;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_start && !busy;

  // Threshold registers
  logic signed [TW-1:0] t_abs_min_r, t_opt_low_r, t_opt_high_r, t_abs_max_r;
  logic        [PW-1:0] p_abs_min_r, p_opt_low_r, p_opt_high_r, p_abs_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_abs_min_r  <= '0;
      t_opt_low_r  <= '0;
      t_opt_high_r <= '0;
      t_abs_max_r  <= '0;
      p_abs_min_r  <= '0;
      p_opt_low_r  <= '0;
      p_opt_high_r <= '0;
      p_abs_max_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cts_pkg::REG_TEMP_ABS_MIN:  t_abs_min_r  <= cfg_data[TW-1:0];
        cts_pkg::REG_TEMP_OPT_LOW:  t_opt_low_r  <= cfg_data[TW-1:0];
        cts_pkg::REG_TEMP_OPT_HIGH: t_opt_high_r <= cfg_data[TW-1:0];
        cts_pkg::REG_TEMP_ABS_MAX:  t_abs_max_r  <= cfg_data[TW-1:0];
        cts_pkg::REG_PREC_ABS_MIN:  p_abs_min_r  <= cfg_data[PW-1:0];
        cts_pkg::REG_PREC_OPT_LOW:  p_opt_low_r  <= cfg_data[PW-1:0];
        cts_pkg::REG_PREC_OPT_HIGH: p_opt_high_r <= cfg_data[PW-1:0];
        cts_pkg::REG_PREC_ABS_MAX:  p_abs_max_r  <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // Extend samples and thresholds to the common signed width
  cts_pkg::thr_t        t_thr, p_thr;
  logic signed [VW-1:0] t_val, p_val;

  assign t_val        = $signed({{(VW-TW){in_data.temperature[TW-1]}}, in_data.temperature});
  assign p_val        = $signed({{(VW-PW){1'b0}}, in_data.precipitation});
  assign t_thr.lo_abs = $signed({{(VW-TW){t_abs_min_r[TW-1]}}, t_abs_min_r});
  assign t_thr.lo_opt = $signed({{(VW-TW){t_opt_low_r[TW-1]}}, t_opt_low_r});
  assign t_thr.hi_opt = $signed({{(VW-TW){t_opt_high_r[TW-1]}}, t_opt_high_r});
  assign t_thr.hi_abs = $signed({{(VW-TW){t_abs_max_r[TW-1]}}, t_abs_max_r});
  assign p_thr.lo_abs = $signed({{(VW-PW){1'b0}}, p_abs_min_r});
  assign p_thr.lo_opt = $signed({{(VW-PW){1'b0}}, p_opt_low_r});
  assign p_thr.hi_opt = $signed({{(VW-PW){1'b0}}, p_opt_high_r});
  assign p_thr.hi_abs = $signed({{(VW-PW){1'b0}}, p_abs_max_r});

  // Membership lanes
  logic               t_vld, p_vld;
  logic [FRAC_BITS:0] t_mem, p_mem;

  cts_trap_lane #(.FRAC_BITS(FRAC_BITS)) u_temp_lane (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_acc),
    .in_val  (t_val),
    .thr     (t_thr),
    .out_vld (t_vld),
    .out_mem (t_mem)
  );

  cts_trap_lane #(.FRAC_BITS(FRAC_BITS)) u_prec_lane (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_acc),
    .in_val  (p_val),
    .thr     (p_thr),
    .out_vld (p_vld),
    .out_mem (p_mem)
  );

  // Missing flag delay line, aligned with the lane outputs
  logic nd_r [0:LANE_LAT-1];

  always_ff @(posedge clk) begin
    nd_r[0] <= in_data.temp_missing || in_data.prec_missing;
    for (int i = 1; i < LANE_LAT; i++) begin
      nd_r[i] <= nd_r[i-1];
    end
  end

  // Result stage: minimum of both memberships, no-data override
  logic               out_valid_r;
  cts_pkg::out_data_t out_data_r;
  logic [FRAC_BITS:0] min_mem;

  assign min_mem = (t_mem < p_mem) ? t_mem : p_mem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= t_vld && p_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.no_data     <= nd_r[LANE_LAT-1];
    out_data_r.suitability <= nd_r[LANE_LAT-1] ? '0 : cts_pkg::OUT_W'(min_mem);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Both lanes stay in lockstep
  a_lane_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    t_vld == p_vld)
    else $error("membership lanes out of step");

  // Every accepted pixel yields a strobe after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##(PIPE_LAT) out_valid)
    else $error("result strobe missing after pipeline latency");

  // A strobe is always caused by an accepted pixel
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, PIPE_LAT))
    else $error("result strobe without a pixel");

  // No-data results carry zero suitability
  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.no_data) |-> (out_data.suitability == '0))
    else $error("no-data result with nonzero suitability");

endmodule

// ----- verif/crop_trapezoid_suitability_core_tb.sv -----
// Self-checking testbench for the crop trapezoid suitability core: directed table, random phases.
`timescale 1ns / 100ps

module crop_trapezoid_suitability_core_tb;

  localparam int TEMP_W = cts_pkg::TEMP_W;
  localparam int PREC_W = cts_pkg::PREC_W;
  localparam int OUT_W = cts_pkg::OUT_W;
  localparam int CFG_IDX_W = cts_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = cts_pkg::CFG_DATA_W;

  localparam int FRAC_BITS = 16;
  localparam int CLK_HALF = 5;
  localparam int PIPE_CYCLES = FRAC_BITS + 3;
  localparam int DRAIN_CYCLES = PIPE_CYCLES + 8;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASES = 12;
  localparam int PIXELS_PER_PHASE = 96;
  localparam int TEMP_MIN = -32768;
  localparam int TEMP_MAX = 32767;
  localparam int PREC_MAX = (1 << PREC_W) - 1;
  localparam logic [OUT_W-1:0] FULL_SUIT = OUT_W'(1 << FRAC_BITS);

  // Threshold set loaded ahead of a directed row
  localparam logic [1:0] SET_KEEP     = 2'd0;
  localparam logic [1:0] SET_TYPICAL  = 2'd1;
  localparam logic [1:0] SET_INVERTED = 2'd2;

  // Register order: temp abs min, opt low, opt high, abs max, then the same for precipitation
  localparam int TYPICAL_THR [8] = '{-1000, 1500, 2500, 4000, 2000, 6000, 12000, 20000};
  localparam int INVERTED_THR [8] = '{-2000, 3000, 1000, 5000, 0, 500000, 100, 1048575};

  localparam int IDLE_PLAN [3] = '{0, 60, 8};

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [PREC_W-1:0]        precipitation;
    logic                     temp_missing;
    logic                     prec_missing;
    logic [1:0]               load_set;
    logic                     typed;
    logic [OUT_W-1:0]         exp_suit;
    logic                     exp_no_data;
  } pixel_row_t;

  localparam int DIRECTED_N = 24;
  localparam pixel_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // reset thresholds: everything sits at or beyond a zero limit
    '{16'sd0,      20'd0,       1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    '{16'sd32767,  20'd1048575, 1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    '{-16'sd32768, 20'd5,       1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    '{16'sd100,    20'd100,     1'b1, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b1},
    // well-ordered thresholds: band, edges, absolute limits, field extremes
    '{16'sd2000,   20'd8000,    1'b0, 1'b0, SET_TYPICAL,  1'b1, FULL_SUIT, 1'b0},
    '{16'sd1500,   20'd6000,    1'b0, 1'b0, SET_KEEP,     1'b1, FULL_SUIT, 1'b0},
    '{16'sd2500,   20'd12000,   1'b0, 1'b0, SET_KEEP,     1'b1, FULL_SUIT, 1'b0},
    '{-16'sd1000,  20'd8000,    1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    '{16'sd4000,   20'd8000,    1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    '{16'sd2000,   20'd2000,    1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    '{16'sd2000,   20'd20000,   1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    '{-16'sd32768, 20'd8000,    1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    '{16'sd32767,  20'd8000,    1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    '{16'sd2000,   20'd0,       1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    '{16'sd2000,   20'd1048575, 1'b0, 1'b0, SET_KEEP,     1'b1, 17'd0, 1'b0},
    // ramps, checked by the predictor
    '{16'sd250,    20'd8000,    1'b0, 1'b0, SET_KEEP,     1'b0, 17'd0, 1'b0},
    '{16'sd3000,   20'd8000,    1'b0, 1'b0, SET_KEEP,     1'b0, 17'd0, 1'b0},
    '{16'sd2000,   20'd4000,    1'b0, 1'b0, SET_KEEP,     1'b0, 17'd0, 1'b0},
    '{16'sd250,    20'd16000,   1'b0, 1'b0, SET_KEEP,     1'b0, 17'd0, 1'b0},
    '{-16'sd999,   20'd19999,   1'b0, 1'b0, SET_KEEP,     1'b0, 17'd0, 1'b0},
    // missing samples
    '{16'sd2000,   20'd8000,    1'b0, 1'b1, SET_KEEP,     1'b1, 17'd0, 1'b1},
    '{-16'sd32768, 20'd1048575, 1'b1, 1'b1, SET_KEEP,     1'b1, 17'd0, 1'b1},
    // optimal bands given in inverted order
    '{16'sd2000,   20'd300,     1'b0, 1'b0, SET_INVERTED, 1'b0, 17'd0, 1'b0},
    '{16'sd4000,   20'd600000,  1'b0, 1'b0, SET_INVERTED, 1'b0, 17'd0, 1'b0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_start;
  cts_pkg::in_data_t      in_data;
  logic                   busy;
  logic                   out_valid;
  cts_pkg::out_data_t     out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Typed expectation travels with the pixel it belongs to
  logic                   row_typed;
  cts_pkg::out_data_t     row_exp;

  logic [CFG_DATA_W-1:0]  thr_shadow [8];
  int                     thr_plan [8];
  cts_pkg::out_data_t     expected_suit_q [$];
  int unsigned            quiet_cycles;
  int unsigned            fail_count;

  crop_trapezoid_suitability_core #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_start(in_start),
    .in_data(in_data),
    .busy(busy),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Trapezoid membership in Q1.FRAC_BITS; limits are exclusive, band edges inclusive
  function automatic longint unsigned membership(longint v, longint lo_abs, longint lo_opt,
                                                 longint hi_opt, longint hi_abs);
    longint span;
    longint num;
    if (v <= lo_abs || v >= hi_abs) return 0;
    if (v >= lo_opt && v <= hi_opt) return longint'(1) << FRAC_BITS;
    if (v < lo_opt) begin
      span = lo_opt - lo_abs;
      num = v - lo_abs;
    end else begin
      span = hi_abs - hi_opt;
      num = hi_abs - v;
    end
    if (span <= 0 || num <= 0) return 0;
    return longint'(unsigned'(num << FRAC_BITS) / unsigned'(span));
  endfunction

  function automatic cts_pkg::out_data_t predict_suitability(cts_pkg::in_data_t px);
    cts_pkg::out_data_t r;
    longint unsigned t_mem;
    longint unsigned p_mem;
    r = '0;
    if (px.temp_missing || px.prec_missing) begin
      r.no_data = 1'b1;
      return r;
    end
    t_mem = membership(longint'(px.temperature),
                       longint'($signed(thr_shadow[cts_pkg::REG_TEMP_ABS_MIN][TEMP_W-1:0])),
                       longint'($signed(thr_shadow[cts_pkg::REG_TEMP_OPT_LOW][TEMP_W-1:0])),
                       longint'($signed(thr_shadow[cts_pkg::REG_TEMP_OPT_HIGH][TEMP_W-1:0])),
                       longint'($signed(thr_shadow[cts_pkg::REG_TEMP_ABS_MAX][TEMP_W-1:0])));
    p_mem = membership(longint'(px.precipitation),
                       longint'(thr_shadow[cts_pkg::REG_PREC_ABS_MIN]),
                       longint'(thr_shadow[cts_pkg::REG_PREC_OPT_LOW]),
                       longint'(thr_shadow[cts_pkg::REG_PREC_OPT_HIGH]),
                       longint'(thr_shadow[cts_pkg::REG_PREC_ABS_MAX]));
    r.suitability = OUT_W'((t_mem < p_mem) ? t_mem : p_mem);
    return r;
  endfunction

  // Scoreboard: tracks register writes, predicts on pixel transfers, checks result strobes
  always @(posedge clk) begin : scoreboard
    cts_pkg::out_data_t want;
    logic progress;
    progress = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        if (cfg_index <= cts_pkg::REG_TEMP_ABS_MAX)
          thr_shadow[cfg_index] = {{(CFG_DATA_W-TEMP_W){1'b0}}, cfg_data[TEMP_W-1:0]};
        else if (cfg_index <= cts_pkg::REG_PREC_ABS_MAX)
          thr_shadow[cfg_index] = cfg_data;
      end
      if (in_start && !busy) begin
        progress = 1'b1;
        want = row_typed ? row_exp : predict_suitability(in_data);
        expected_suit_q.push_back(want);
      end
      if (out_valid) begin
        progress = 1'b1;
        if (expected_suit_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result suit=%0d no_data=%0b", $realtime,
                     out_data.suitability, out_data.no_data);
        end else begin
          want = expected_suit_q.pop_front();
          if (out_data.suitability !== want.suitability || out_data.no_data !== want.no_data) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch suit exp=%0d got=%0d, no_data exp=%0b got=%0b",
                       $realtime, want.suitability, out_data.suitability,
                       want.no_data, out_data.no_data);
          end
        end
      end
    end
    // Watchdog on cycles without any transfer
    quiet_cycles = progress ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int clamp_to(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int rand_temp();
    return int'($signed(16'($urandom)));
  endfunction

  // Ascending sort of the four thresholds starting at base
  task automatic sort_plan(int base);
    int t;
    for (int i = 0; i < 3; i++)
      for (int j = base; j < base + 3 - i; j++)
        if (thr_plan[j] > thr_plan[j+1]) begin
          t = thr_plan[j];
          thr_plan[j] = thr_plan[j+1];
          thr_plan[j+1] = t;
        end
  endtask

  // Field value aimed at the planned thresholds: band, near an edge, anywhere, or an extreme
  function automatic int pick_near(int lo_lim, int hi_lim, int base);
    int lo;
    int hi;
    int v;
    lo = thr_plan[base];
    hi = thr_plan[base];
    for (int i = 1; i < 4; i++) begin
      if (thr_plan[base+i] < lo) lo = thr_plan[base+i];
      if (thr_plan[base+i] > hi) hi = thr_plan[base+i];
    end
    case ($urandom_range(0, 9)) inside
      [0:4]: v = lo - 4 + int'($urandom_range(0, hi - lo + 8));
      [5:6]: v = thr_plan[base + int'($urandom_range(0, 3))] + int'($urandom_range(0, 2)) - 1;
      [7:8]: v = lo_lim + int'($urandom_range(0, hi_lim - lo_lim));
      default: v = $urandom_range(0, 1) ? hi_lim : lo_lim;
    endcase
    return clamp_to(v, lo_lim, hi_lim);
  endfunction

  // Threshold setting for a random phase: ordered, extreme, unordered or degenerate
  task automatic plan_thresholds(int phase);
    int c;
    int scale;
    case (phase % 4)
      0: begin
        scale = $urandom_range(8, PREC_W);
        for (int i = 0; i < 4; i++) begin
          thr_plan[i] = rand_temp();
          thr_plan[i+4] = $urandom_range(0, (1 << scale) - 1);
        end
        sort_plan(0);
        sort_plan(4);
      end
      1: begin
        if (phase == 5) begin
          thr_plan = '{TEMP_MIN, TEMP_MIN, TEMP_MAX, TEMP_MAX, 0, 0, PREC_MAX, PREC_MAX};
        end else if (phase == 9) begin
          thr_plan = '{TEMP_MAX, TEMP_MAX, TEMP_MIN, TEMP_MIN, PREC_MAX, PREC_MAX, 0, 0};
        end else begin
          thr_plan = '{TEMP_MIN, rand_temp(), rand_temp(), TEMP_MAX,
                       0, int'($urandom_range(0, PREC_MAX)), int'($urandom_range(0, PREC_MAX)),
                       PREC_MAX};
          sort_plan(0);
          sort_plan(4);
        end
      end
      2: begin
        c = rand_temp();
        for (int i = 0; i < 4; i++)
          thr_plan[i] = clamp_to(c + int'($urandom_range(0, 4000)) - 2000, TEMP_MIN, TEMP_MAX);
        c = $urandom_range(0, PREC_MAX);
        for (int i = 4; i < 8; i++)
          thr_plan[i] = clamp_to(c + int'($urandom_range(0, 40000)) - 20000, 0, PREC_MAX);
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          thr_plan[i] = clamp_to(rand_temp() / 8, TEMP_MIN, TEMP_MAX);
          thr_plan[i+4] = $urandom_range(0, 60000);
        end
        sort_plan(0);
        sort_plan(4);
        // collapse ramps or the band to zero width
        for (int b = 0; b < 8; b += 4) begin
          if ($urandom_range(0, 1)) thr_plan[b+1] = thr_plan[b];
          if ($urandom_range(0, 1)) thr_plan[b+2] = thr_plan[b+3];
          if ($urandom_range(0, 3) == 0) thr_plan[b+2] = thr_plan[b+1];
        end
      end
    endcase
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all eight thresholds plus one write to an unmapped index
  task automatic program_thresholds();
    for (int i = 0; i < 8; i++) begin
      if (i <= int'(cts_pkg::REG_TEMP_ABS_MAX))
        cfg_write(CFG_IDX_W'(i), {(CFG_DATA_W-TEMP_W)'($urandom), TEMP_W'(thr_plan[i])});
      else
        cfg_write(CFG_IDX_W'(i), CFG_DATA_W'(thr_plan[i]));
      if (i == int'(cts_pkg::REG_TEMP_ABS_MAX))
        cfg_write(CFG_IDX_W'($urandom_range(int'(cts_pkg::REG_PREC_ABS_MAX) + 1,
                                            (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and let every result in flight come back
  task automatic wait_idle();
    @(negedge clk);
    in_start <= 1'b0;
    while (expected_suit_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_pixel(cts_pkg::in_data_t px, logic typed, cts_pkg::out_data_t exp_r,
                            int idle_pct);
    @(negedge clk);
    while (idle_pct > 0 && int'($urandom_range(1, 100)) <= idle_pct) begin
      in_start <= 1'b0;
      @(negedge clk);
    end
    in_start <= 1'b1;
    in_data <= px;
    row_typed <= typed;
    row_exp <= exp_r;
    do @(posedge clk); while (busy);
  endtask

  initial begin : stimulus
    pixel_row_t row;
    cts_pkg::in_data_t px;
    cts_pkg::out_data_t exp_r;
    rst_n = 1'b0;
    in_start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    row_typed = 1'b0;
    row_exp = '0;
    quiet_cycles = 0;
    fail_count = 0;
    for (int i = 0; i < 8; i++) thr_shadow[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int r = 0; r < DIRECTED_N; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.load_set != SET_KEEP) begin
        wait_idle();
        if (row.load_set == SET_TYPICAL)
          thr_plan = TYPICAL_THR;
        else
          thr_plan = INVERTED_THR;
        program_thresholds();
      end
      px.temperature = row.temperature;
      px.precipitation = row.precipitation;
      px.temp_missing = row.temp_missing;
      px.prec_missing = row.prec_missing;
      exp_r.suitability = row.exp_suit;
      exp_r.no_data = row.exp_no_data;
      send_pixel(px, row.typed, exp_r, 0);
    end

    // Random phases, each with its own thresholds and sender idling
    for (int p = 0; p < PHASES; p++) begin
      plan_thresholds(p);
      wait_idle();
      program_thresholds();
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        px.temperature = TEMP_W'(pick_near(TEMP_MIN, TEMP_MAX, 0));
        px.precipitation = PREC_W'(pick_near(0, PREC_MAX, 4));
        px.temp_missing = ($urandom_range(0, 9) == 0);
        px.prec_missing = ($urandom_range(0, 9) == 0);
        send_pixel(px, 1'b0, '0, IDLE_PLAN[p % 3]);
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
